[design/rsa_pkg.sv]
package rsa_pkg;
  localparam int STACK_DEPTH = 64;
  localparam int AW = $clog2(STACK_DEPTH);
  localparam int CW = $clog2(STACK_DEPTH + 1);

  typedef enum logic [3:0] {
    CMD_PUSH = 4'd0, CMD_PEEK = 4'd1, CMD_POP = 4'd2, CMD_ADD = 4'd3,
    CMD_SUB = 4'd4, CMD_MUL = 4'd5, CMD_DIV = 4'd6, CMD_GT = 4'd7,
    CMD_LT = 4'd8, CMD_GE = 4'd9, CMD_LE = 4'd10, CMD_EQ = 4'd11,
    CMD_MOD = 4'd12, CMD_SWAP = 4'd13, CMD_SHOW = 4'd14, CMD_NOP = 4'd15
  } cmd_t;

  localparam logic [1:0] ST_OK = 2'd0;
  localparam logic [1:0] ST_UNDER = 2'd1;
  localparam logic [1:0] ST_OVER = 2'd2;
  localparam logic [1:0] ST_DIVZ = 2'd3;

  typedef struct packed {
    cmd_t        cmd;
    logic [31:0] pv;
  } qitem_t;
endpackage

[design/rpn_stack_alu.sv]
// rpn_stack_alu: reverse-Polish integer stack machine, 64 x 32-bit stack.
// Input channel (valid/ready): command and push_value, one item per
// command. A two-entry queue in the front accepts items while the back
// executes. Output channel (valid/ready): value, status, depth, last.
// Every command gives one result item with last=1, except show on a
// non-empty stack: one item per stack entry, bottom first, last=1 on top.
// Stack RAM reads are registered: peek and pop read the top entry and the
// other operators read the top two entries before they execute; div and
// mod then run the bit-serial 32-step divider. Show reads the entries one
// by one, each read registered before its item goes out.
// The back end takes the next command in the cycle after the previous
// result item has been taken.
// Reset (rst, synchronous) empties the stack and the queue; RAM contents
// are not cleared since only written entries are ever read.
// When the receiver stalls, the result holds; the back end waits, and
// the queue keeps taking items until both entries are full.
module rpn_stack_alu import rsa_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [3:0]  command,
  input  logic signed [31:0] push_value,
  output logic        out_valid,
  input  logic        out_ready,
  output logic signed [31:0] value,
  output logic [1:0]  status,
  output logic [6:0]  depth,
  output logic        last
);
  logic   q_valid, q_ready;
  qitem_t q_item;
  logic [31:0] val_u;

  rsa_front u_front (
    .clk(clk), .rst(rst), .valid(in_valid), .ready(in_ready),
    .command(command), .push_value(push_value),
    .q_valid(q_valid), .q_ready(q_ready), .q_item(q_item)
  );
  rsa_back u_back (
    .clk(clk), .rst(rst), .q_valid(q_valid), .q_ready(q_ready), .q_item(q_item),
    .out_valid(out_valid), .out_ready(out_ready), .value(val_u),
    .status(status), .depth(depth), .last(last)
  );
  assign value = val_u;
endmodule

[design/rsa_ram.sv]
module rsa_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) mem[waddr] <= wdata;
    rdata <= mem[raddr];
  end
endmodule

[design/rsa_front.sv]
module rsa_front import rsa_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        valid,
  output logic        ready,
  input  logic [3:0]  command,
  input  logic [31:0] push_value,
  output logic        q_valid,
  input  logic        q_ready,
  output qitem_t      q_item
);
  // two-entry queue
  qitem_t      buf0, buf1;
  logic [1:0]  cnt;
  logic        push, pop;

  assign ready   = (cnt != 2'd2);
  assign q_valid = (cnt != 2'd0);
  assign q_item  = buf0;
  assign push    = valid && ready;
  assign pop     = q_valid && q_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      cnt <= 2'd0;
    end else begin
      cnt <= cnt + {1'b0, push} - {1'b0, pop};
    end
    if (pop) begin
      if (push && cnt == 2'd1) buf0 <= {cmd_t'(command), push_value};
      else buf0 <= buf1;
    end else if (push) begin
      if (cnt == 2'd0) buf0 <= {cmd_t'(command), push_value};
      else buf1 <= {cmd_t'(command), push_value};
    end
  end
endmodule

[design/rsa_div.sv]
module rsa_div import rsa_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  input  logic [31:0] a,
  input  logic [31:0] b,
  output logic        done,
  output logic [31:0] quo,
  output logic [31:0] rem
);
  logic [31:0] ua, ub, q, r;
  logic [5:0]  cnt;
  logic        busy, na, nb;
  logic [32:0] trial;

  assign trial = {r, q[31]} - {1'b0, ub};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= 6'd0;
        na   <= a[31];
        nb   <= b[31];
        q    <= a[31] ? 32'd0 - a : a;
        ub   <= b[31] ? 32'd0 - b : b;
        r    <= 32'd0;
      end else if (busy) begin
        if (!trial[32]) r <= trial[31:0];
        else r <= {r[30:0], q[31]};
        q <= {q[30:0], ~trial[32]};
        cnt <= cnt + 6'd1;
        if (cnt == 6'd31) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  assign ua  = q;
  assign quo = (na != nb) ? 32'd0 - ua : ua;
  assign rem = na ? 32'd0 - r : r;
endmodule

[design/rsa_back.sv]
module rsa_back import rsa_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        q_valid,
  output logic        q_ready,
  input  qitem_t      q_item,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [31:0] value,
  output logic [1:0]  status,
  output logic [6:0]  depth,
  output logic        last
);
  typedef enum logic [6:0] {
    S_IDLE = 7'b0000001, S_RD1 = 7'b0000010, S_RD2 = 7'b0000100,
    S_EXEC = 7'b0001000, S_DIV = 7'b0010000, S_SHOW = 7'b0100000,
    S_OUT  = 7'b1000000
  } state_t;

  state_t      state;
  qitem_t      it;
  logic [CW-1:0] n;
  logic [31:0] a, b, r;
  logic [CW-1:0] idx;
  logic        we;
  logic [AW-1:0] waddr, raddr;
  logic [31:0] wdata, rdata;
  logic        dstart, ddone, rdpend, sw2;
  logic [31:0] quo, rem;
  logic [63:0] prod;
  logic        slt, sgt;
  logic [31:0] ex_value;
  logic [1:0]  ex_status;
  logic [CW-1:0] ex_n;
  logic        ex_div, ex_sw2;
  logic        out_valid_next;

  rsa_ram #(.WIDTH(32), .DEPTH(STACK_DEPTH)) u_ram (
    .clk(clk), .we(we), .waddr(waddr), .wdata(wdata), .raddr(raddr), .rdata(rdata)
  );
  rsa_div u_div (
    .clk(clk), .rst(rst), .start(dstart), .a(a), .b(b),
    .done(ddone), .quo(quo), .rem(rem)
  );

  // a new command waits until the previous result item has been taken
  assign q_ready = (state == S_IDLE) && !sw2 && !out_valid;
  assign slt  = $signed(a) < $signed(b);
  assign sgt  = $signed(b) < $signed(a);
  assign prod = a * b;
  assign dstart = (state == S_EXEC) && ex_div;

  // outcome of the command once its operands are in a and b
  always_comb begin
    ex_value = 32'd0;
    ex_status = ST_OK;
    ex_n = n;
    ex_div = 1'b0;
    ex_sw2 = 1'b0;
    unique case (it.cmd) inside
      CMD_PUSH: if (n == CW'(STACK_DEPTH)) ex_status = ST_OVER;
        else begin
          ex_value = it.pv; ex_n = n + CW'(1);
        end
      CMD_PEEK, CMD_POP: if (n == '0) ex_status = ST_UNDER;
        else begin
          ex_value = b;
          if (it.cmd == CMD_POP) ex_n = n - CW'(1);
        end
      CMD_SHOW, CMD_NOP: ;
      default: if (n < CW'(2)) ex_status = ST_UNDER;
        else if (it.cmd == CMD_SWAP) begin
          ex_value = a; ex_sw2 = 1'b1;
        end else if (it.cmd == CMD_DIV || it.cmd == CMD_MOD) begin
          if (b == 32'd0) ex_status = ST_DIVZ;
          else ex_div = 1'b1;
        end else begin
          ex_value = r; ex_n = n - CW'(1);
        end
    endcase
  end

  always_comb begin
    we = 1'b0;
    waddr = AW'(n);
    wdata = it.pv;
    raddr = AW'(idx);
    // reads are registered: address top in IDLE, second in RD1
    if (state == S_IDLE) raddr = AW'(n - CW'(1));
    else if (state == S_RD1) raddr = AW'(n - CW'(2));
    if (sw2) begin
      we = 1'b1;
      waddr = AW'(n - CW'(1));
      wdata = a;
    end else if (state == S_EXEC && ex_status == ST_OK) begin
      unique case (it.cmd) inside
        CMD_PUSH: we = 1'b1;
        CMD_ADD, CMD_SUB, CMD_MUL, CMD_GT, CMD_LT, CMD_GE, CMD_LE, CMD_EQ,
        CMD_SWAP: begin
          we = 1'b1;
          waddr = AW'(n - CW'(2));
          wdata = (it.cmd == CMD_SWAP) ? b : r;
        end
        default: ;
      endcase
    end else if (state == S_DIV && ddone) begin
      we = 1'b1;
      waddr = AW'(n - CW'(2));
      wdata = (it.cmd == CMD_MOD) ? rem : quo;
    end
  end

  always_comb begin
    r = 32'd0;
    case (it.cmd)
      CMD_ADD: r = a + b;
      CMD_SUB: r = a - b;
      CMD_MUL: r = prod[31:0];
      CMD_GT:  r = {31'd0, sgt};
      CMD_LT:  r = {31'd0, slt};
      CMD_GE:  r = {31'd0, !slt};
      CMD_LE:  r = {31'd0, !sgt};
      CMD_EQ:  r = {31'd0, a == b};
      default: r = 32'd0;
    endcase
  end

  always_comb begin
    out_valid_next = out_valid && !out_ready;
    if (state == S_OUT && (!out_valid || out_ready)) out_valid_next = 1'b1;
    if (state == S_SHOW && (!out_valid || out_ready) && rdpend) out_valid_next = 1'b1;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      n <= '0;
      out_valid <= 1'b0;
      sw2 <= 1'b0;
      rdpend <= 1'b0;
    end else begin
      sw2 <= (state == S_EXEC) && ex_sw2;
      out_valid <= out_valid_next;
      unique case (state)
        S_IDLE: if (q_valid && q_ready) begin
          it <= q_item;
          unique case (q_item.cmd) inside
            CMD_PUSH, CMD_NOP: state <= S_EXEC;
            CMD_PEEK, CMD_POP: state <= (n == '0) ? S_EXEC : S_RD2;
            CMD_SHOW: begin
              idx <= '0;
              rdpend <= 1'b0;
              state <= (n == '0) ? S_EXEC : S_SHOW;
            end
            default: state <= (n < CW'(2)) ? S_EXEC : S_RD1;
          endcase
        end
        S_RD1: begin
          b <= rdata;
          state <= S_RD2;
        end
        S_RD2: begin
          if (it.cmd == CMD_PEEK || it.cmd == CMD_POP) b <= rdata;
          else a <= rdata;
          state <= S_EXEC;
        end
        S_EXEC: begin
          value <= ex_value; status <= ex_status; depth <= 7'(ex_n); last <= 1'b1;
          n <= ex_n;
          state <= ex_div ? S_DIV : S_OUT;
        end
        S_DIV: if (ddone) begin
          value <= (it.cmd == CMD_MOD) ? rem : quo;
          n <= n - CW'(1); depth <= 7'(n - CW'(1));
          state <= S_OUT;
        end
        S_SHOW: if (!out_valid || out_ready) begin
          if (rdpend) begin
            value <= rdata; status <= ST_OK; depth <= 7'(n);
            last <= (idx == n);
            rdpend <= 1'b0;
            if (idx == n) state <= S_IDLE;
          end else begin
            idx <= idx + CW'(1);
            rdpend <= 1'b1;
          end
        end
        S_OUT: if (!out_valid || out_ready) begin
          state <= S_IDLE;
        end
        default: state <= S_IDLE;
      endcase
    end
  end
endmodule

[tb/sv/rpn_stack_alu_test.sv]
module rpn_stack_alu_test;
  import rsa_pkg::*;

  localparam int WATCHDOG_LIMIT = 20000;
  localparam int DRAIN_CYCLES = 200;

  typedef struct {
    logic signed [31:0] value;
    logic [1:0]         status;
    logic [6:0]         depth;
    logic               last;
  } result_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic in_valid = 1'b0;
  logic in_ready;
  logic [3:0] command = CMD_NOP;
  logic signed [31:0] push_value = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  logic signed [31:0] value;
  logic [1:0] status;
  logic [6:0] depth;
  logic last;

  rpn_stack_alu dut (
    .clk(clk), .rst(rst), .in_valid(in_valid), .in_ready(in_ready),
    .command(command), .push_value(push_value), .out_valid(out_valid),
    .out_ready(out_ready), .value(value), .status(status), .depth(depth),
    .last(last)
  );

  // predictor state
  logic [31:0] stack_mem [STACK_DEPTH];
  int          stack_cnt;
  result_t     pending_results[$];
  int          errors;
  int          idle_cycles;
  int          send_idle_pct;
  int          recv_stall_pct;

  initial forever #6 clk = ~clk;

  function automatic void expect_result(logic [31:0] v, logic [1:0] st, int d, logic l);
    result_t r;
    r.value = v;
    r.status = st;
    r.depth = d[6:0];
    r.last = l;
    pending_results.push_back(r);
  endfunction

  function automatic logic [31:0] signed_divide(logic [31:0] a, logic [31:0] b, bit want_rem);
    logic [31:0] ua, ub, q, r;
    ua = a[31] ? -a : a;
    ub = b[31] ? -b : b;
    q = ua / ub;
    r = ua % ub;
    if (want_rem) return a[31] ? -r : r;
    return (a[31] != b[31]) ? -q : q;
  endfunction

  function automatic void predict_command(cmd_t cmd, logic [31:0] pv);
    logic [31:0] a, b, r;
    case (cmd)
      CMD_PUSH: begin
        if (stack_cnt >= STACK_DEPTH) begin
          expect_result('0, ST_OVER, stack_cnt, 1'b1);
        end else begin
          stack_mem[stack_cnt] = pv;
          stack_cnt++;
          expect_result(pv, ST_OK, stack_cnt, 1'b1);
        end
      end
      CMD_PEEK, CMD_POP: begin
        if (stack_cnt == 0) begin
          expect_result('0, ST_UNDER, 0, 1'b1);
        end else begin
          r = stack_mem[stack_cnt - 1];
          if (cmd == CMD_POP) stack_cnt--;
          expect_result(r, ST_OK, stack_cnt, 1'b1);
        end
      end
      CMD_SHOW: begin
        if (stack_cnt == 0) expect_result('0, ST_OK, 0, 1'b1);
        for (int k = 0; k < stack_cnt; k++)
          expect_result(stack_mem[k], ST_OK, stack_cnt, k == stack_cnt - 1);
      end
      CMD_NOP: expect_result('0, ST_OK, stack_cnt, 1'b1);
      default: begin
        if (stack_cnt < 2) begin
          expect_result('0, ST_UNDER, stack_cnt, 1'b1);
          return;
        end
        b = stack_mem[stack_cnt - 1];
        a = stack_mem[stack_cnt - 2];
        if (cmd == CMD_SWAP) begin
          stack_mem[stack_cnt - 2] = b;
          stack_mem[stack_cnt - 1] = a;
          expect_result(a, ST_OK, stack_cnt, 1'b1);
          return;
        end
        if ((cmd == CMD_DIV || cmd == CMD_MOD) && b == 0) begin
          expect_result('0, ST_DIVZ, stack_cnt, 1'b1);
          return;
        end
        case (cmd)
          CMD_ADD: r = a + b;
          CMD_SUB: r = a - b;
          CMD_MUL: r = a * b;
          CMD_DIV: r = signed_divide(a, b, 1'b0);
          CMD_MOD: r = signed_divide(a, b, 1'b1);
          CMD_GT:  r = ($signed(a) > $signed(b)) ? 1 : 0;
          CMD_LT:  r = ($signed(a) < $signed(b)) ? 1 : 0;
          CMD_GE:  r = ($signed(a) >= $signed(b)) ? 1 : 0;
          CMD_LE:  r = ($signed(a) <= $signed(b)) ? 1 : 0;
          default: r = (a == b) ? 1 : 0;
        endcase
        stack_cnt--;
        stack_mem[stack_cnt - 1] = r;
        expect_result(r, ST_OK, stack_cnt, 1'b1);
      end
    endcase
  endfunction

  // result checker and receiver stalls
  always @(posedge clk) begin
    result_t e;
    if (!rst) begin
      if (out_valid && out_ready) begin
        if (pending_results.size() == 0) begin
          $error("unexpected result value=%0d status=%0d", value, status);
          errors++;
        end else begin
          e = pending_results.pop_front();
          if (value !== e.value) begin
            $error("value exp %0d got %0d", e.value, value); errors++;
          end
          if (status !== e.status) begin
            $error("status exp %0d got %0d", e.status, status); errors++;
          end
          if (depth !== e.depth) begin
            $error("depth exp %0d got %0d", e.depth, depth); errors++;
          end
          if (last !== e.last) begin
            $error("last exp %0d got %0d", e.last, last); errors++;
          end
        end
      end
      out_ready <= ($urandom_range(99) >= recv_stall_pct);
    end
  end

  // watchdog: cycles with no handshake on either side
  always @(posedge clk) begin
    if (rst || (in_valid && in_ready) || (out_valid && out_ready)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= WATCHDOG_LIMIT) begin
        $display("[FAIL] regression broken");
        $finish;
      end
    end
  end

  // valid stays up after an accept until the next item or an idle cycle
  task automatic send_item(cmd_t cmd, logic [31:0] pv);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    command <= cmd;
    push_value <= pv;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    predict_command(cmd, pv);
  endtask

  task automatic wait_drained();
    in_valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
  endtask

  function automatic logic [31:0] pick_value();
    case ($urandom_range(5))
      0: return 32'h8000_0000;
      1: return 32'h7fff_ffff;
      2: return 32'hffff_ffff;
      3: return 32'(int'($urandom_range(6)) - 3);
      default: return $urandom;
    endcase
  endfunction

  task automatic test_directed();
    send_item(CMD_PEEK, '0);
    send_item(CMD_POP, '0);
    send_item(CMD_ADD, '0);
    send_item(CMD_SHOW, '0);
    send_item(CMD_NOP, 32'hffff_ffff);
    send_item(CMD_PUSH, 32'h8000_0000);
    send_item(CMD_SWAP, '0);
    send_item(CMD_PUSH, 32'hffff_ffff);
    send_item(CMD_DIV, '0);
    send_item(CMD_PUSH, 32'hffff_ffff);
    send_item(CMD_PUSH, 32'h8000_0000);
    send_item(CMD_PUSH, 32'hffff_ffff);
    send_item(CMD_MOD, '0);
    send_item(CMD_PUSH, 32'h0);
    send_item(CMD_DIV, '0);
    send_item(CMD_MOD, '0);
    send_item(CMD_PUSH, 32'h7fff_ffff);
    send_item(CMD_SHOW, '0);
    send_item(CMD_SWAP, '0);
    send_item(CMD_PEEK, '0);
    send_item(CMD_POP, '0);
    wait_drained();
    // clear stack
    while (stack_cnt > 0) send_item(CMD_POP, '0);
  endtask

  task automatic test_ops_random(int count);
    cmd_t cmd;
    for (int i = 0; i < count; i++) begin
      if (stack_cnt < 3 || $urandom_range(2) == 0) cmd = CMD_PUSH;
      else cmd = cmd_t'($urandom_range(15));
      if (cmd == CMD_SHOW && $urandom_range(3) != 0) cmd = CMD_ADD;
      send_item(cmd, pick_value());
    end
  endtask

  task automatic test_fill_overflow();
    while (stack_cnt < STACK_DEPTH) send_item(CMD_PUSH, $urandom);
    send_item(CMD_PUSH, 32'h1234_5678);
    send_item(CMD_SHOW, '0);
    send_item(CMD_MUL, '0);
    // sender holds off until all results are back
    wait_drained();
    while (stack_cnt > 0) send_item($urandom_range(1) ? CMD_POP : CMD_SUB, '0);
  endtask

  initial begin
    errors = 0;
    stack_cnt = 0;
    send_idle_pct = 0;
    recv_stall_pct = 0;
    repeat (2) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_directed();
    test_ops_random(50);
    send_idle_pct = 53;
    test_ops_random(50);
    send_idle_pct = 0;
    recv_stall_pct = 53;
    test_fill_overflow();
    test_ops_random(40);
    send_idle_pct = 9;
    recv_stall_pct = 9;
    test_ops_random(40);
    send_idle_pct = 0;
    recv_stall_pct = 0;
    wait_drained();
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (errors == 0 && pending_results.size() == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end
endmodule
